// ----- rtl/core/lru_key_set_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LRU key set assertion macros
// Shared concurrent assertion forms used by the LRU key set unit.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_SET_UNIT_MACROS_SVH
`define LRU_KEY_SET_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LKS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LKS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lks_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key set package
// Field widths, defaults and request kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lks_pkg;

   localparam int KEY_W        = 48;
   localparam int KIND_W       = 2;
   localparam int DEF_CAPACITY = 64;
   localparam int DEF_OCC_W    = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

endpackage

`default_nettype wire

// ----- rtl/core/lks_ifs.sv -----
// ----------------------------------------------------------------------------
// LRU key set channels
// Valid/ready request and response channels of the LRU key set unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface lks_req_if;
   logic                     valid;
   logic                     ready;
   logic [lks_pkg::KIND_W-1:0] kind;
   logic [lks_pkg::KEY_W-1:0]  block_key;

   modport source (output valid, output kind, output block_key, input ready);
   modport sink   (input valid, input kind, input block_key, output ready);
endinterface

interface lks_rsp_if #(
   parameter int OCC_W = lks_pkg::DEF_OCC_W
);
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic                      evicted;
   logic [lks_pkg::KEY_W-1:0] evicted_key;
   logic [OCC_W-1:0]          occupancy;

   modport source (output valid, output hit, output evicted, output evicted_key,
                   output occupancy, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_key,
                   input occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lru_key_set_unit.sv -----
// ----------------------------------------------------------------------------
// LRU key set unit: fully associative least-recently-used set of block keys
// Add and lookup scan the entries; a hit or an add then walks them again to
// update the ranks. Clear and unused kinds go straight to the response beat.
// Request ready rises again in the cycle after the response beat.
// Reset (synchronous) empties the set and idles the sequencer; RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_set_unit_macros.svh"

module lru_key_set_unit #(
   parameter int CAPACITY = lks_pkg::DEF_CAPACITY
) (
   input  wire logic  clock,
   input  wire logic  reset,     // synchronous, active high: empties the set
   lks_req_if.sink    req_bus,
   lks_rsp_if.source  rsp_bus
);

   // Entry index and recency rank share one width; the count must also hold
   // CAPACITY itself. The response occupancy field is driven from the CNT_W-wide count.
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W  = lks_pkg::KEY_W;
   localparam int ENT_W  = KEY_W + RANK_W;

   // ST_SCAN  : walk entries 0..count-1, find the key and the oldest entry
   // ST_UPDATE: walk them again, age the entries younger than the target,
   //            make the target most recent
   // ST_RESP  : hold the response beat until it is taken
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // ------------------------------------------------------------------------
   // Entry RAM: {key, rank} per slot. Valid slots are always 0..count-1,
   // because an add fills the lowest free slot and only a clear or reset frees slots,
   // so the fill count stands in for per-entry valid bits.
   // ------------------------------------------------------------------------
   logic [ENT_W-1:0] entry_mem [CAPACITY];
   logic [ENT_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ENT_W-1:0] mem_wdata;

   // Control state
   state_type        state_ff,   state_in;
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic [CNT_W-1:0] ptr_ff,     ptr_in;
   logic             rvld_ff,    rvld_in;

   // Working registers for one request
   logic [CNT_W-1:0]            lim_ff,      lim_in;
   logic [IDX_W-1:0]            ridx_ff,     ridx_in;
   logic [lks_pkg::KIND_W-1:0]  kind_ff,     kind_in;
   logic [KEY_W-1:0]            key_ff,      key_in;
   logic                        found_ff,    found_in;
   logic [IDX_W-1:0]            slot_ff,     slot_in;
   logic [CNT_W-1:0]            thr_ff,      thr_in;
   logic                        have_old_ff, have_old_in;
   logic [IDX_W-1:0]            old_idx_ff,  old_idx_in;
   logic [RANK_W-1:0]           old_rank_ff, old_rank_in;
   logic [KEY_W-1:0]            old_key_ff,  old_key_in;

   // Response registers
   logic             hit_ff,   hit_in;
   logic             ev_ff,    ev_in;
   logic [KEY_W-1:0] evkey_ff, evkey_in;

   logic              rd_issue;
   logic              pass_done;
   logic [KEY_W-1:0]  rd_key;
   logic [RANK_W-1:0] rd_rank;
   logic              full;

   assign rd_key  = rd_data_ff[ENT_W-1 -: KEY_W];
   assign rd_rank = rd_data_ff[RANK_W-1:0];
   assign full    = (cnt_ff == CNT_W'(CAPACITY));

   // A read goes out each cycle of a pass until the pointer meets the limit;
   // the pass is over once the last read data has been consumed.
   assign rd_issue  = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) &&
                      (ptr_ff != lim_ff);
   assign pass_done = !rd_issue && !rvld_ff;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_RESP);
   assign rsp_bus.hit         = hit_ff;
   assign rsp_bus.evicted     = ev_ff;
   assign rsp_bus.evicted_key = evkey_ff;
   assign rsp_bus.occupancy   = cnt_ff;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      rvld_in     = 1'b0;
      ridx_in     = ridx_ff;
      lim_in      = lim_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      thr_in      = thr_ff;
      have_old_in = have_old_ff;
      old_idx_in  = old_idx_ff;
      old_rank_in = old_rank_ff;
      old_key_in  = old_key_ff;
      hit_in      = hit_ff;
      ev_in       = ev_ff;
      evkey_in    = evkey_ff;
      mem_we      = 1'b0;
      mem_waddr   = ridx_ff;
      mem_wdata   = {key_ff, RANK_W'(0)};

      // Advance the read pointer; tag the data that returns next cycle.
      if (rd_issue) begin
         ptr_in  = ptr_ff + CNT_W'(1);
         rvld_in = 1'b1;
         ridx_in = ptr_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in     = req_bus.kind;
               key_in      = req_bus.block_key;
               hit_in      = 1'b0;
               ev_in       = 1'b0;
               evkey_in    = '0;
               found_in    = 1'b0;
               have_old_in = 1'b0;
               lim_in      = cnt_ff;
               ptr_in      = '0;
               unique case (req_bus.kind)
                  lks_pkg::KIND_ADD,
                  lks_pkg::KIND_LOOKUP: state_in = ST_SCAN;
                  lks_pkg::KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;   // unused kind: report count only
               endcase
            end
         end

         ST_SCAN: begin
            if (rvld_ff) begin
               // Keys are unique among valid entries; keep the first match.
               if (!found_ff && (rd_key == key_ff)) begin
                  found_in = 1'b1;
                  slot_in  = ridx_ff;
                  thr_in   = CNT_W'(rd_rank);
               end
               // Track the least recent entry for a possible eviction.
               if (!have_old_ff || (rd_rank > old_rank_ff)) begin
                  have_old_in = 1'b1;
                  old_idx_in  = ridx_ff;
                  old_rank_in = rd_rank;
                  old_key_in  = rd_key;
               end
            end
            if (pass_done) begin
               ptr_in = '0;
               priority if (found_ff) begin
                  // Hit on add or lookup: refresh the entry.
                  hit_in   = 1'b1;
                  state_in = ST_UPDATE;
               end else if ((kind_ff == lks_pkg::KIND_ADD) && !full) begin
                  // Append in the first free slot; every older entry ages.
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[IDX_W-1:0];
                  mem_wdata = {key_ff, RANK_W'(0)};
                  slot_in   = cnt_ff[IDX_W-1:0];
                  thr_in    = cnt_ff + CNT_W'(1);
                  cnt_in    = cnt_ff + CNT_W'(1);
                  state_in  = ST_UPDATE;
               end else if ((kind_ff == lks_pkg::KIND_ADD) && have_old_ff) begin
                  // Full: drop the least recent entry and reuse its slot.
                  slot_in  = old_idx_ff;
                  thr_in   = CNT_W'(old_rank_ff);
                  ev_in    = 1'b1;
                  evkey_in = old_key_ff;
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_RESP;    // lookup miss: nothing changes
               end
            end
         end

         ST_UPDATE: begin
            if (rvld_ff) begin
               mem_waddr = ridx_ff;
               if (ridx_ff == slot_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = {key_ff, RANK_W'(0)};
               end else if (CNT_W'(rd_rank) < thr_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = {rd_key, RANK_W'(rd_rank + RANK_W'(1))};
               end
            end
            if (pass_done) begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs. Reset clears control state only.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ptr_ff      <= ptr_in;
         rvld_ff     <= rvld_in;
         ridx_ff     <= ridx_in;
         lim_ff      <= lim_in;
         kind_ff     <= kind_in;
         key_ff      <= key_in;
         found_ff    <= found_in;
         slot_ff     <= slot_in;
         thr_ff      <= thr_in;
         have_old_ff <= have_old_in;
         old_idx_ff  <= old_idx_in;
         old_rank_ff <= old_rank_in;
         old_key_ff  <= old_key_in;
         hit_ff      <= hit_in;
         ev_ff       <= ev_in;
         evkey_ff    <= evkey_in;
      end
   end

   // Entry RAM: one write and one registered read per cycle. The read and write
   // addresses of an update pass never coincide (the write goes to the address read just before).
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[ptr_ff[IDX_W-1:0]];
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `LKS_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(CAPACITY),
                   "count above capacity")
   `LKS_ASSERT_NOW(a_evict_full, clock, reset, rsp_bus.valid && ev_ff,
                   full && !hit_ff, "eviction without full set or with hit")
   `LKS_ASSERT_NEXT(a_clear_empty, clock, reset,
                    req_bus.valid && req_bus.ready && (req_bus.kind == lks_pkg::KIND_CLEAR),
                    (cnt_ff == '0) && rsp_bus.valid, "clear did not empty the set")
   `LKS_ASSERT_NOW(a_write_in_range, clock, reset, mem_we,
                   CNT_W'(mem_waddr) <= cnt_ff, "write beyond the next free slot")

endmodule

`default_nettype wire
